[rtl/pea_pkg.sv]
package pea_pkg;

  localparam int unsigned PageW      = 12;
  localparam int unsigned CountW     = 13;
  localparam int unsigned StatW      = 2;
  localparam int unsigned TotalPages = 4096;

  typedef enum logic [StatW-1:0] {
    ST_OK      = 2'd0,
    ST_NOPAGES = 2'd1,
    ST_FULL    = 2'd2,
    ST_BAD     = 2'd3
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } command_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_SCAN,
    S_A_DECIDE,
    S_A_RDBEST,
    S_A_SPLIT,
    S_F_SCAN,
    S_F_CHECK,
    S_F_LSCAN,
    S_F_RSCAN,
    S_F_RDONE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [0:0]        command;
    logic [CountW-1:0] req_pages;
    logic [PageW-1:0]  req_start;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [PageW-1:0]  out_start;
    logic [CountW-1:0] out_pages;
  } rsp_t;

endpackage

[rtl/pea_if.sv]
interface pea_req_if;
  logic          valid;
  logic          ready;
  pea_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pea_rsp_if;
  logic          valid;
  logic          ready;
  pea_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pea_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [pea_pkg::CountW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/page_extent_allocator.sv]
// Best-fit page extent allocator with coalescing on free.
// Channels: req (command, req_pages, req_start), rsp (status, out_start,
// out_pages), cfg (pool_pages write data). Each moves one item per transfer
// on valid and ready both high.
// One request at a time: req_ready is high only while idle and no result
// is pending. The extent table is a memory with a registered read port and
// a separate write port, walked one entry per cycle. Steps per request:
//   allocate: a best-fit scan over all entries, then a decision; with a
//     split, the remainder entry and then the best entry are written. The
//     best-fit scan also finds the lowest unused slot. Zero-page request:
//     rejected with ST_BAD at once. free: lookup, left and right neighbour
//     scans; each scan stops early when its entry is found.
// The result sits in an output register until taken; a stalled receiver
// only holds the block in its done state.
// Reset clears the valid bits, the bump pointer and sets pool_pages to
// 4096. Table contents are not cleared; no clearing pass is needed.
// cfg writes are accepted every cycle.
module page_extent_allocator #(
  parameter int unsigned MAX_EXTENTS = 64
) (
  input logic clk_i,
  input logic rst_ni,
  pea_req_if.sink   req_i,
  pea_rsp_if.source rsp_o,
  pea_cfg_if.sink   cfg_i
);
  import pea_pkg::*;

  localparam int unsigned IdxW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned LimW = (CountW > $clog2(TotalPages + 1)) ? CountW + 1
                                 : $clog2(TotalPages + 1) + 1;
  localparam logic [LimW-1:0] TotalLim = LimW'(TotalPages);

  typedef struct packed {
    logic [PageW-1:0]  start;
    logic [CountW-1:0] pages;
    logic              is_free;
  } ent_t;

  ent_t                   mem_q [MAX_EXTENTS];
  ent_t                   rd_q;
  logic [MAX_EXTENTS-1:0] vld_q, vld_d;

  state_e            state_q, state_d;
  req_t              req_q, req_d;
  rsp_t              rsp_q, rsp_d;
  logic [CountW-1:0] pool_q;
  logic [CountW-1:0] fresh_q, fresh_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              hit_q, hit_d;
  logic [IdxW-1:0]   best_q, best_d;
  ent_t              bent_q, bent_d;
  logic              slot_ok_q, slot_ok_d;
  logic [IdxW-1:0]   slot_q, slot_d;
  logic [IdxW-1:0]   cur_q, cur_d;
  ent_t              cent_q, cent_d;

  logic              rd_en, wr_en;
  logic [IdxW-1:0]   rd_addr, wr_addr;
  ent_t              wr_data;

  logic [IdxW-1:0]   pidx;
  logic              pvld;
  logic              scan_last;
  logic [LimW-1:0]   limit, fresh_ext, req_ext;
  logic [CountW-1:0] rd_end, cur_end;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = (state_q == S_DONE);
  assign rsp_o.data  = rsp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  // entry read last cycle, at index cnt_q-1
  assign pidx      = IdxW'(cnt_q - CntW'(1));
  assign pvld      = vld_q[pidx];
  assign scan_last = (cnt_q == CntW'(MAX_EXTENTS));
  assign rd_end    = CountW'(rd_q.start) + rd_q.pages;
  assign cur_end   = CountW'(cent_q.start) + cent_q.pages;
  assign limit     = (LimW'(pool_q) < TotalLim) ? LimW'(pool_q) : TotalLim;
  assign fresh_ext = LimW'(fresh_q);
  assign req_ext   = LimW'(req_q.req_pages);

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    rsp_d     = rsp_q;
    fresh_d   = fresh_q;
    vld_d     = vld_q;
    cnt_d     = cnt_q;
    hit_d     = hit_q;
    best_d    = best_q;
    bent_d    = bent_q;
    slot_ok_d = slot_ok_q;
    slot_d    = slot_q;
    cur_d     = cur_q;
    cent_d    = cent_q;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          req_d     = req_i.data;
          hit_d     = 1'b0;
          slot_ok_d = 1'b0;
          cnt_d     = '0;
          rd_en     = 1'b1;
          rd_addr   = '0;
          cnt_d     = CntW'(1);
          if (req_i.data.command == CMD_ALLOC) begin
            if (req_i.data.req_pages == '0) begin
              rsp_d   = '{ST_BAD, '0, '0};
              state_d = S_DONE;
            end else begin
              state_d = S_A_SCAN;
            end
          end else begin
            state_d = S_F_SCAN;
          end
        end
      end

      S_A_SCAN: begin
        if (!pvld && !slot_ok_q) begin
          slot_ok_d = 1'b1;
          slot_d    = pidx;
        end
        if (pvld && rd_q.is_free && rd_q.pages >= req_q.req_pages &&
            (!hit_q || rd_q.pages < bent_q.pages ||
             (rd_q.pages == bent_q.pages && rd_q.start < bent_q.start))) begin
          hit_d  = 1'b1;
          best_d = pidx;
          bent_d = rd_q;
        end
        if (scan_last) begin
          state_d = S_A_DECIDE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IdxW'(cnt_q);
          cnt_d   = cnt_q + CntW'(1);
        end
      end

      S_A_DECIDE: begin
        if (hit_q) begin
          if (bent_q.pages > req_q.req_pages) begin
            if (!slot_ok_q) begin
              rsp_d   = '{ST_FULL, '0, '0};
              state_d = S_DONE;
            end else begin
              state_d = S_A_SPLIT;
            end
          end else begin
            wr_en   = 1'b1;
            wr_addr = best_q;
            wr_data = '{bent_q.start, bent_q.pages, 1'b0};
            rsp_d   = '{ST_OK, bent_q.start, req_q.req_pages};
            state_d = S_DONE;
          end
        end else if (fresh_ext > limit || req_ext > limit - fresh_ext) begin
          rsp_d   = '{ST_NOPAGES, '0, '0};
          state_d = S_DONE;
        end else if (!slot_ok_q) begin
          rsp_d   = '{ST_FULL, '0, '0};
          state_d = S_DONE;
        end else begin
          wr_en          = 1'b1;
          wr_addr        = slot_q;
          wr_data        = '{PageW'(fresh_q), req_q.req_pages, 1'b0};
          vld_d[slot_q]  = 1'b1;
          fresh_d        = fresh_q + req_q.req_pages;
          rsp_d          = '{ST_OK, PageW'(fresh_q), req_q.req_pages};
          state_d        = S_DONE;
        end
      end

      S_A_SPLIT: begin
        wr_en         = 1'b1;
        wr_addr       = slot_q;
        wr_data       = '{bent_q.start + PageW'(req_q.req_pages),
                          bent_q.pages - req_q.req_pages, 1'b1};
        vld_d[slot_q] = 1'b1;
        state_d       = S_A_RDBEST;
      end

      S_A_RDBEST: begin
        wr_en   = 1'b1;
        wr_addr = best_q;
        wr_data = '{bent_q.start, req_q.req_pages, 1'b0};
        rsp_d   = '{ST_OK, bent_q.start, req_q.req_pages};
        state_d = S_DONE;
      end

      S_F_SCAN: begin
        if (pvld && rd_q.start == req_q.req_start) begin
          cur_d   = pidx;
          cent_d  = rd_q;
          state_d = S_F_CHECK;
        end else if (scan_last) begin
          rsp_d   = '{ST_BAD, '0, '0};
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IdxW'(cnt_q);
          cnt_d   = cnt_q + CntW'(1);
        end
      end

      S_F_CHECK: begin
        if (cent_q.is_free) begin
          rsp_d   = '{ST_BAD, '0, '0};
          state_d = S_DONE;
        end else begin
          cent_d.is_free = 1'b1;
          wr_en   = 1'b1;
          wr_addr = cur_q;
          wr_data = '{cent_q.start, cent_q.pages, 1'b1};
          rd_en   = 1'b1;
          rd_addr = '0;
          cnt_d   = CntW'(1);
          state_d = S_F_LSCAN;
        end
      end

      S_F_LSCAN: begin
        if (pidx != cur_q && pvld && rd_q.is_free &&
            rd_end == CountW'(cent_q.start)) begin
          wr_en        = 1'b1;
          wr_addr      = pidx;
          wr_data      = '{rd_q.start, rd_q.pages + cent_q.pages, 1'b1};
          vld_d[cur_q] = 1'b0;
          cur_d        = pidx;
          cent_d       = wr_data;
          rd_en        = 1'b1;
          rd_addr      = '0;
          cnt_d        = CntW'(1);
          state_d      = S_F_RSCAN;
        end else if (scan_last) begin
          rd_en   = 1'b1;
          rd_addr = '0;
          cnt_d   = CntW'(1);
          state_d = S_F_RSCAN;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IdxW'(cnt_q);
          cnt_d   = cnt_q + CntW'(1);
        end
      end

      S_F_RSCAN: begin
        if (pidx != cur_q && pvld && rd_q.is_free &&
            CountW'(rd_q.start) == cur_end) begin
          wr_en       = 1'b1;
          wr_addr     = cur_q;
          wr_data     = '{cent_q.start, cent_q.pages + rd_q.pages, 1'b1};
          vld_d[pidx] = 1'b0;
          cent_d      = wr_data;
          state_d     = S_F_RDONE;
        end else if (scan_last) begin
          state_d = S_F_RDONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IdxW'(cnt_q);
          cnt_d   = cnt_q + CntW'(1);
        end
      end

      S_F_RDONE: begin
        rsp_d   = '{ST_OK, cent_q.start, cent_q.pages};
        state_d = S_DONE;
      end

      S_DONE: begin
        if (rsp_o.ready) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vld_q   <= '0;
      fresh_q <= '0;
      pool_q  <= CountW'(4096);
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
      fresh_q <= fresh_d;
      cnt_q   <= cnt_d;
      if (cfg_i.valid) pool_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    rsp_q     <= rsp_d;
    hit_q     <= hit_d;
    best_q    <= best_d;
    bent_q    <= bent_d;
    slot_ok_q <= slot_ok_d;
    slot_q    <= slot_d;
    cur_q     <= cur_d;
    cent_q    <= cent_d;
  end

  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !req_i.ready)
    else $error("ready while busy");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready) |=> (rsp_o.valid && $stable(rsp_o.data)))
    else $error("result dropped");
  a_fresh_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fresh_q != $past(fresh_q)) |-> ($past(state_q) == S_A_DECIDE))
    else $error("bump pointer moved outside allocate");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.data.status != ST_OK) |->
      (rsp_o.data.out_pages == '0 && rsp_o.data.out_start == '0))
    else $error("error result carries data");

endmodule

[tb/tb_if.sv]
`timescale 1ns / 100ps
// Channel interfaces come from the RTL (pea_if.sv); this file carries the
// testbench-side row type shared with the top.
package tb_alloc_pkg;
  import pea_pkg::*;

  typedef struct {
    command_e    cmd;
    logic [12:0] pages;
    logic [11:0] start;
    bit          has_exp;
    status_e     exp_status;
    logic [11:0] exp_start;
    logic [12:0] exp_pages;
  } stim_row_t;
endpackage

[tb/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;
  import pea_pkg::*;
  import tb_alloc_pkg::*;

  localparam int NumExt = 64;
  localparam int NumRand = 1000;

  logic clk_i;
  logic rst_ni;

  pea_req_if req_if ();
  pea_rsp_if rsp_if ();
  pea_cfg_if cfg_if ();

  page_extent_allocator DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source),
    .cfg_i (cfg_if.sink)
  );

  // predictor state
  logic [11:0] ext_start [NumExt];
  logic [12:0] ext_pages [NumExt];
  bit          ext_free  [NumExt];
  bit          ext_valid [NumExt];
  int unsigned bump_ptr;
  int unsigned pool_limit;

  rsp_t expected_rsps[$];
  int   errors;
  bit   hold_off;
  bit   calm;
  int   live_starts[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int lowest_unused();
    for (int i = 0; i < NumExt; i++) if (!ext_valid[i]) return i;
    return -1;
  endfunction

  function automatic rsp_t predict_alloc(int unsigned req);
    rsp_t r;
    int best, slot;
    int unsigned lim;
    best = -1;
    r = '{status: ST_OK, out_start: '0, out_pages: '0};
    if (req == 0) begin
      r.status = ST_BAD;
      return r;
    end
    for (int i = 0; i < NumExt; i++) begin
      if (!ext_valid[i] || !ext_free[i] || ext_pages[i] < req) continue;
      if (best < 0 || ext_pages[i] < ext_pages[best] ||
          (ext_pages[i] == ext_pages[best] && ext_start[i] < ext_start[best]))
        best = i;
    end
    if (best >= 0) begin
      if (ext_pages[best] > req) begin
        slot = lowest_unused();
        if (slot < 0) begin
          r.status = ST_FULL;
          return r;
        end
        ext_valid[slot] = 1;
        ext_free[slot]  = 1;
        ext_start[slot] = 12'(ext_start[best] + req);
        ext_pages[slot] = 13'(ext_pages[best] - req);
        ext_pages[best] = 13'(req);
      end
      ext_free[best] = 0;
      r.out_start = ext_start[best];
      r.out_pages = 13'(req);
      return r;
    end
    lim = pool_limit < 4096 ? pool_limit : 4096;
    if (bump_ptr > lim || req > lim - bump_ptr) begin
      r.status = ST_NOPAGES;
      return r;
    end
    slot = lowest_unused();
    if (slot < 0) begin
      r.status = ST_FULL;
      return r;
    end
    ext_valid[slot] = 1;
    ext_free[slot]  = 0;
    ext_start[slot] = 12'(bump_ptr);
    ext_pages[slot] = 13'(req);
    r.out_start = 12'(bump_ptr);
    r.out_pages = 13'(req);
    bump_ptr += req;
    return r;
  endfunction

  function automatic rsp_t predict_free(logic [11:0] start);
    rsp_t r;
    int cur;
    int unsigned tail;
    cur = -1;
    r = '{status: ST_BAD, out_start: '0, out_pages: '0};
    for (int i = 0; i < NumExt; i++)
      if (ext_valid[i] && ext_start[i] == start) begin
        cur = i;
        break;
      end
    if (cur < 0 || ext_free[cur]) return r;
    ext_free[cur] = 1;
    for (int i = 0; i < NumExt; i++)
      if (i != cur && ext_valid[i] && ext_free[i] &&
          int'(ext_start[i]) + int'(ext_pages[i]) == int'(ext_start[cur])) begin
        ext_pages[i] += ext_pages[cur];
        ext_valid[cur] = 0;
        cur = i;
        break;
      end
    tail = int'(ext_start[cur]) + int'(ext_pages[cur]);
    for (int i = 0; i < NumExt; i++)
      if (i != cur && ext_valid[i] && ext_free[i] && ext_start[i] == tail) begin
        ext_pages[cur] += ext_pages[i];
        ext_valid[i] = 0;
        break;
      end
    r.status    = ST_OK;
    r.out_start = ext_start[cur];
    r.out_pages = ext_pages[cur];
    return r;
  endfunction

  task automatic wait_idle();
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (3 * NumExt + 20) @(posedge clk_i);
  endtask

  task automatic write_pool(logic [12:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    pool_limit = 32'(val);
  endtask

  task automatic send_req(command_e cmd, logic [12:0] pages, logic [11:0] start,
                          bit has_exp = 0, rsp_t exp_rsp = '0);
    rsp_t p;
    req_if.valid <= 1'b1;
    req_if.data  <= '{command: cmd, req_pages: pages, req_start: start};
    do @(posedge clk_i); while (!req_if.ready);
    p = (cmd == CMD_ALLOC) ? predict_alloc(pages) : predict_free(start);
    if (has_exp && p != exp_rsp) begin
      $error("directed row: predicted %p, typed %p", p, exp_rsp);
      errors++;
    end
    expected_rsps.push_back(p);
    if (p.status == ST_OK && cmd == CMD_ALLOC) live_starts.push_back(int'(p.out_start));
    if (!calm && $urandom_range(99) < 13) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // response side
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("transfer with no expected result");
          errors++;
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (rsp_if.data.status != e.status) begin
            $error("status: expected %0d actual %0d", e.status, rsp_if.data.status);
            errors++;
          end
          if (rsp_if.data.out_start != e.out_start) begin
            $error("out_start: expected %0d actual %0d", e.out_start,
                   rsp_if.data.out_start);
            errors++;
          end
          if (rsp_if.data.out_pages != e.out_pages) begin
            $error("out_pages: expected %0d actual %0d", e.out_pages,
                   rsp_if.data.out_pages);
            errors++;
          end
        end
      end
      rsp_if.ready <= hold_off ? 1'b0 : (calm ? 1'b1 : ($urandom_range(99) >= 13));
    end
  end

  task automatic run_random(int n);
    int idx;
    logic [12:0] pg;
    logic [11:0] st;
    for (int k = 0; k < n; k++) begin
      calm = (k >= n / 3 && k < n / 2);
      if ($urandom_range(99) < 55 || live_starts.size() == 0) begin
        case ($urandom_range(9))
          0: pg = 13'($urandom_range(8191));
          1: pg = 0;
          2: pg = 13'($urandom_range(1, 512));
          default: pg = 13'($urandom_range(1, 40));
        endcase
        send_req(CMD_ALLOC, pg, 12'($urandom_range(4095)));
      end else begin
        if ($urandom_range(9) == 0) begin
          st = 12'($urandom_range(4095));
        end else begin
          idx = $urandom_range(live_starts.size() - 1);
          st = 12'(live_starts[idx]);
          live_starts.delete(idx);
        end
        send_req(CMD_FREE, 13'($urandom_range(8191)), st);
      end
    end
    calm = 0;
    req_if.valid <= 1'b0;
  endtask

  stim_row_t rows[$];

  initial begin
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    errors = 0;
    hold_off = 0;
    calm = 0;
    bump_ptr = 0;
    pool_limit = 4096;
    foreach (ext_valid[i]) begin
      ext_valid[i] = 0;
      ext_free[i] = 0;
      ext_start[i] = '0;
      ext_pages[i] = '0;
    end
    rows = '{
      '{CMD_ALLOC, 13'd0,    12'd0,  1, ST_BAD,     12'd0,  13'd0},
      '{CMD_FREE,  13'd0,    12'd0,  1, ST_BAD,     12'd0,  13'd0},
      '{CMD_ALLOC, 13'd4097, 12'd0,  1, ST_NOPAGES, 12'd0,  13'd0},
      '{CMD_ALLOC, 13'd8191, 12'hfff, 1, ST_NOPAGES, 12'd0, 13'd0},
      '{CMD_ALLOC, 13'd10,   12'd0,  1, ST_OK,      12'd0,  13'd10},
      '{CMD_ALLOC, 13'd20,   12'd0,  1, ST_OK,      12'd10, 13'd20},
      '{CMD_ALLOC, 13'd5,    12'd0,  1, ST_OK,      12'd30, 13'd5},
      '{CMD_ALLOC, 13'd1,    12'd0,  1, ST_OK,      12'd35, 13'd1},
      '{CMD_FREE,  13'd0,    12'd10, 1, ST_OK,      12'd10, 13'd20},
      '{CMD_FREE,  13'd0,    12'd10, 1, ST_BAD,     12'd0,  13'd0},
      '{CMD_FREE,  13'd0,    12'd0,  1, ST_OK,      12'd0,  13'd30},
      '{CMD_FREE,  13'd0,    12'd35, 1, ST_OK,      12'd35, 13'd1},
      '{CMD_ALLOC, 13'd7,    12'd0,  0, ST_OK,      12'd0,  13'd0},
      '{CMD_FREE,  13'd0,    12'd30, 0, ST_OK,      12'd0,  13'd0},
      '{CMD_ALLOC, 13'd1,    12'd0,  0, ST_OK,      12'd0,  13'd0},
      '{CMD_ALLOC, 13'd4000, 12'd0,  0, ST_OK,      12'd0,  13'd0},
      '{CMD_ALLOC, 13'd1,    12'hfff, 0, ST_OK,     12'd0,  13'd0},
      '{CMD_FREE,  13'd0,    12'hfff, 1, ST_BAD,    12'd0,  13'd0}
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i])
      send_req(rows[i].cmd, rows[i].pages, rows[i].start, rows[i].has_exp,
               '{status: rows[i].exp_status, out_start: rows[i].exp_start,
                 out_pages: rows[i].exp_pages});
    req_if.valid <= 1'b0;
    wait_idle();

    // fill the table with one-page extents, split from free space or fresh, to reach the full case
    write_pool(13'd8191);
    for (int k = 0; k < 70; k++) send_req(CMD_ALLOC, 13'd1, 12'd0);
    req_if.valid <= 1'b0;
    wait_idle();

    // free a batch of extents
    for (int k = 0; k < 3; k++) begin
      int idx;
      idx = $urandom_range(live_starts.size() - 1);
      send_req(CMD_FREE, 13'd0, 12'(live_starts[idx]));
      live_starts.delete(idx);
    end
    for (int k = 0; k < 20; k++) send_req(CMD_FREE, 13'd0, 12'(live_starts.pop_front()));
    req_if.valid <= 1'b0;
    wait_idle();

    // receiver holds off while the sender keeps offering
    fork
      begin
        hold_off = 1;
        repeat (2000) @(posedge clk_i);
        hold_off = 0;
      end
      run_random(NumRand / 4);
    join
    wait_idle();

    write_pool(13'd1);
    run_random(NumRand / 4);
    wait_idle();
    write_pool(13'd4096);
    run_random(NumRand / 4);
    wait_idle();
    write_pool(13'($urandom_range(1, 8191)));
    run_random(NumRand / 4);

    wait_idle();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
